// File: hw/rtl/dcps_pkg.sv
// Shared types and constants for the divisor count pair sum block.
package dcps_pkg;

  localparam int VALUE_BITS = 32;
  localparam int COUNT_W    = 11;
  localparam int SUM_W      = 64;
  localparam int PRIME_W    = 17;  // trial divisor, reaches just past 2^16
  localparam int EXP_W      = 6;   // exponent of one prime, at most 31
  localparam int DIV_CNT_W  = 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_WAIT,
    S_NEXT,
    S_TAIL,
    S_SUM
  } dcps_state_t;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [PRIME_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [PRIME_W-1:0]    remainder;
  } div_rsp_t;

endpackage

// File: hw/rtl/divisor_count_pair_sum.sv
// Top level: divisor count by trial division and running pair-product sum.
// Trial divisors are 2 then odd numbers while d*d <= residue. Each division issues the
//   request, shifts in 32 quotient bits and signals done; a failed trial also passes the
//   check and step states. The slowest input is a prime near 2^32.
// Throughput: one beat at a time; in_stall is high from accept until the result is
//   written to the output register.
// Reset (synchronous, rst high): sequencer idle, output empty, sum and previous count cleared.
module divisor_count_pair_sum
  import dcps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] number,
  input  logic                  restart,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COUNT_W-1:0]    divisor_count,
  output logic [SUM_W-1:0]      pair_sum
);

  dcps_state_t state, state_next;

  logic [VALUE_BITS-1:0] residue;
  logic [PRIME_W-1:0]    prime;
  logic [EXP_W-1:0]      expo;
  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    previous_count;
  logic                  have_previous;
  logic [SUM_W-1:0]      running_sum;
  logic                  clear_pending;

  div_req_t req;
  div_rsp_t rsp;

  logic [2*PRIME_W-1:0]  prime_sq;
  logic                  past_root;
  logic                  out_free;
  logic [COUNT_W+EXP_W:0] count_prod;
  logic [2*COUNT_W-1:0]  pair_prod;

  // Trial divisors 2, 3, 5, 7, ...: composites never divide since their
  // factors are already gone. Stopping at p*p > residue matches stopping at
  // p*p > n, since a leftover residue is then 1 or a prime.
  assign prime_sq   = prime * prime;
  assign past_root  = prime_sq > (2*PRIME_W)'(residue);
  assign out_free   = !out_valid || !out_stall;
  assign count_prod = count * ({1'b0, expo} + 1'b1);
  assign pair_prod  = previous_count * count;

  dcps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_CHECK;
      S_CHECK: state_next = past_root ? S_TAIL : S_DIV;
      S_DIV:   state_next = S_WAIT;
      S_WAIT: begin
        if (rsp.done) begin
          state_next = (rsp.remainder == '0) ? S_DIV : S_NEXT;
        end
      end
      S_NEXT:  state_next = S_CHECK;
      S_TAIL:  state_next = S_SUM;
      S_SUM:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall     = (state != S_IDLE);
    req.start    = (state == S_DIV);
    req.dividend = residue;
    req.divisor  = prime;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath of the current number
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        residue <= number;
        prime   <= PRIME_W'(2);
        expo    <= '0;
        count   <= COUNT_W'(1);
      end
      S_WAIT: begin
        if (rsp.done && rsp.remainder == '0) begin
          residue <= rsp.quotient;
          expo    <= expo + 1'b1;
        end
      end
      S_NEXT: begin
        count <= count_prod[COUNT_W-1:0];
        expo  <= '0;
        prime <= (prime == PRIME_W'(2)) ? PRIME_W'(3) : prime + PRIME_W'(2);
      end
      S_TAIL: begin
        if (residue > VALUE_BITS'(1)) count <= {count[COUNT_W-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  // pair sum and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      have_previous  <= 1'b0;
      previous_count <= '0;
      running_sum    <= '0;
      clear_pending  <= 1'b0;
    end else begin
      if (state == S_IDLE && in_valid) clear_pending <= restart;
      if (state == S_SUM && out_free) begin
        out_valid      <= 1'b1;
        divisor_count  <= count;
        previous_count <= count;
        have_previous  <= 1'b1;
        if (clear_pending) begin
          running_sum <= '0;
          pair_sum    <= '0;
        end else if (have_previous) begin
          running_sum <= running_sum + SUM_W'(pair_prod);
          pair_sum    <= running_sum + SUM_W'(pair_prod);
        end else begin
          pair_sum <= running_sum;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_WAIT)) else $error("divider result outside wait");
  a_prime_min: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (prime >= PRIME_W'(2))) else $error("bad trial divisor");
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM) |-> (count != '0)) else $error("zero divisor count");

endmodule

// File: hw/rtl/dcps_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module dcps_div
  import dcps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [VALUE_BITS-1:0] quo;
  logic [PRIME_W-1:0]    rem;
  logic [PRIME_W-1:0]    dsr;
  logic                  done;
  logic [PRIME_W:0]      rem_shift;
  logic                  fits;

  assign rem_shift = {rem, quo[VALUE_BITS-1]};
  assign fits      = rem_shift >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(VALUE_BITS - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(VALUE_BITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      quo <= {quo[VALUE_BITS-2:0], fits};
      rem <= fits ? PRIME_W'(rem_shift - {1'b0, dsr}) : rem_shift[PRIME_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// File: tb/sv/dcps_checker.sv
// Checker for the divisor count pair sum block: predicts each result and compares it.
`timescale 1ns / 1ps
module dcps_checker
  import dcps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [VALUE_BITS-1:0] number,
  input  logic                  restart,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [COUNT_W-1:0]    divisor_count,
  input  logic [SUM_W-1:0]      pair_sum,
  output int                    mismatches,
  output int                    pending
);

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
  } dcps_result_t;

  dcps_result_t       expected_results[$];
  logic [COUNT_W-1:0] prev_count;
  logic               prev_valid;
  logic [SUM_W-1:0]   pair_total;

  // Trial division over 2 then odd divisors.
  function automatic logic [COUNT_W-1:0] divisor_count_of(logic [VALUE_BITS-1:0] n);
    longint unsigned r;
    longint unsigned p;
    int unsigned     d;
    int unsigned     e;
    r = n;
    p = 2;
    d = 1;
    while (p * p <= r) begin
      e = 0;
      while (r % p == 0) begin
        r = r / p;
        e++;
      end
      d = d * (e + 1);
      p = (p == 2) ? 3 : p + 2;
    end
    if (r > 1) d = d * 2;
    return d[COUNT_W-1:0];
  endfunction

  always @(posedge clk) begin
    dcps_result_t       exp_r;
    logic [COUNT_W-1:0] d;
    if (rst) begin
      prev_count <= '0;
      prev_valid <= 1'b0;
      pair_total <= '0;
      mismatches <= 0;
      pending    <= 0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        d = divisor_count_of(number);
        exp_r.count = d;
        if (restart) exp_r.sum = '0;
        else if (prev_valid) exp_r.sum = pair_total + SUM_W'(prev_count) * SUM_W'(d);
        else exp_r.sum = pair_total;
        pair_total <= exp_r.sum;
        prev_count <= d;
        prev_valid <= 1'b1;
        expected_results.push_back(exp_r);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected beat: count %0d sum %0d", divisor_count, pair_sum);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.count !== divisor_count || exp_r.sum !== pair_sum) begin
            if (mismatches < 10)
              $display("beat mismatch: count exp %0d got %0d, sum exp %0d got %0d",
                       exp_r.count, divisor_count, exp_r.sum, pair_sum);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for divisor_count_pair_sum.
`timescale 1ns / 1ps
module tb_top;
  import dcps_pkg::*;

  localparam int RANDOM_ITEMS = 100;
  localparam int CALM_TAIL    = 20;       // last beats run with no idling
  localparam int CYCLE_LIMIT  = 4000000;  // several times the slowest expected run
  localparam int DRAIN_CYCLES = 50;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] number = '0;
  logic                  restart = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COUNT_W-1:0]    divisor_count;
  logic [SUM_W-1:0]      pair_sum;
  int                    mismatches;
  int                    pending;
  bit                    calm = 1'b0;
  int                    cycles = 0;

  logic [VALUE_BITS-1:0] num_q[$];
  bit                    rst_q[$];

  always #5 clk = ~clk;

  divisor_count_pair_sum i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .number(number), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .divisor_count(divisor_count), .pair_sum(pair_sum)
  );

  dcps_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .number(number), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .divisor_count(divisor_count), .pair_sum(pair_sum),
    .mismatches(mismatches), .pending(pending)
  );

  // Run-away guard. The block is slow on large prime cofactors, so the
  // stimulus keeps cofactors small and this limit stays far out of reach.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver back-pressure: random stall bursts, off in the quiet stretch mid-run and near the end.
  always @(posedge clk) begin
    int burst;
    if (burst > 0) begin
      burst = burst - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      burst = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Product of small factors that fits 32 bits: large value, tiny cofactor,
  // so the trial division ends early and the high bits get exercised.
  function automatic logic [VALUE_BITS-1:0] smooth_number();
    longint unsigned v;
    longint unsigned f;
    v = 1;
    for (int i = 0; i < 40; i++) begin
      f = $urandom_range(2, 60);
      if (v * f <= 64'hFFFF_FFFF) v = v * f;
    end
    return v[VALUE_BITS-1:0];
  endfunction

  task automatic add_beat(logic [VALUE_BITS-1:0] n, bit r);
    num_q.push_back(n);
    rst_q.push_back(r);
  endtask

  initial begin
    int unsigned base;
    int          run_len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero and one, first beat after reset, a restart, powers of two,
    // all-ones, a highly composite value (large count), a run of neighbors.
    add_beat(32'd0, 1'b0);
    add_beat(32'd1, 1'b0);
    add_beat(32'd2, 1'b0);
    add_beat(32'd3, 1'b0);
    add_beat(32'd4, 1'b1);
    add_beat(32'd5, 1'b0);
    add_beat(32'd6, 1'b0);
    add_beat(32'h8000_0000, 1'b0);
    add_beat(32'hFFFF_FFFF, 1'b0);
    add_beat(32'd3491888400, 1'b0);
    add_beat(32'd2147483648 + 32'd0, 1'b1);
    add_beat(32'd65535, 1'b0);
    add_beat(32'd65536, 1'b0);
    add_beat(32'd65537, 1'b0);
    add_beat(32'd720720, 1'b0);
    add_beat(32'd720721, 1'b0);
    add_beat(32'd4294967040, 1'b0);  // 2^32 - 256
    add_beat(32'd0, 1'b1);
    add_beat(32'd1, 1'b0);

    // Random: mostly runs of consecutive small numbers, some with a restart at the
    // head, mixed with large smooth values that break the sequence.
    while (num_q.size() < 19 + RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        add_beat(smooth_number(), $urandom_range(0, 7) == 0);
      end else begin
        base = $urandom_range(1, 20000);
        run_len = $urandom_range(3, 12);
        for (int i = 0; i < run_len; i++)
          add_beat(base + i, i == 0 && $urandom_range(0, 1) == 1);
      end
    end

    foreach (num_q[i]) begin
      // Random sender gaps; a quiet stretch mid-run and none at the end.
      calm = (i >= num_q.size() - CALM_TAIL) || (i >= 50 && i < 65);
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      in_valid <= 1'b1;
      number   <= num_q[i];
      restart  <= rst_q[i];
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/dcps_pkg.sv
hw/rtl/dcps_div.sv
hw/rtl/divisor_count_pair_sum.sv
tb/sv/dcps_checker.sv
tb/sv/tb_top.sv
